/* sv/pct_pkg.sv */
// Package for the prefix count trie: request codes and sequencer states.
// Used by prefix_count_trie; depends on nothing.
package pct_pkg;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_CHILD,
    ST_WAIT_CHILD,
    ST_DECIDE,
    ST_ZERO_ROW,
    ST_RD_COUNT,
    ST_WAIT_COUNT,
    ST_WR_COUNT,
    ST_DEL_CNT,
    ST_DEL_CNT_W,
    ST_DEL_PATH,
    ST_DEL_PWAIT,
    ST_DEL_NRD,
    ST_DEL_NWAIT,
    ST_DEL_NWR,
    ST_OUT
  } state_t;

endpackage

/* sv/prefix_count_trie.sv */
// Prefix count trie top level: handshake, sequencer and the three memories.
// Depends on pct_pkg.
//
// A pooled trie over an alphabet of ALPHABET letters. Strings arrive one
// letter per item on the in_ channel, with in_last marking the final letter
// and in_req_type choosing insert, delete prefix, query prefix or clear.
// Each node carries a saturating pass count. Only a query item with
// in_last set produces a result item (out_found, out_overflow); every other
// item produces none. The block works on one item at a time and is not
// ready meanwhile. A walk step issues one registered child table read, and a
// query result holds the block until out_ready takes it. Allocating a node
// zeroes its row one entry per cycle through the single child table write
// port. A delete ending a string rewalks its stored path and then zeroes the
// cut row. A clear zeroes the root row. No clearing pass follows reset: the
// root row is tracked by a valid bit, and every other row and count is
// written on allocation before any read. A full pool or a delete longer than
// MAX_LEN sets the sticky overflow flag, which only reset clears.
module prefix_count_trie #(
  parameter int NODES       = 4096,
  parameter int ALPHABET    = 26,
  parameter int MAX_LEN     = 512,
  parameter int COUNT_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_req_type,
  input  logic [4:0] in_letter,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_found,
  output logic       out_overflow
);

  localparam int NW = $clog2(NODES);
  localparam int AW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
  localparam int SW = $clog2(NODES * ALPHABET);
  localparam int PW = $clog2(MAX_LEN);
  localparam int DW = $clog2(MAX_LEN + 1);
  localparam int FW = $clog2(NODES + 1);
  localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

  // Memories: child table, pass counts, path store.
  logic [NW-1:0]          child_mem [NODES*ALPHABET];
  logic [COUNT_WIDTH-1:0] count_mem [NODES];
  logic [NW-1:0]          path_mem  [MAX_LEN];

  logic [SW-1:0] cm_addr;
  logic          cm_we;
  logic [NW-1:0] cm_wdata, cm_rdata_r;
  logic [NW-1:0] ct_addr;
  logic          ct_we;
  logic [COUNT_WIDTH-1:0] ct_wdata, ct_rdata_r;
  logic [PW-1:0] pm_addr;
  logic          pm_we;
  logic [NW-1:0] pm_wdata, pm_rdata_r;

  always_ff @(posedge clk) begin
    if (cm_we) begin
      child_mem[cm_addr] <= cm_wdata;
    end
    cm_rdata_r <= child_mem[cm_addr];
  end

  always_ff @(posedge clk) begin
    if (ct_we) begin
      count_mem[ct_addr] <= ct_wdata;
    end
    ct_rdata_r <= count_mem[ct_addr];
  end

  always_ff @(posedge clk) begin
    if (pm_we) begin
      path_mem[pm_addr] <= pm_wdata;
    end
    pm_rdata_r <= path_mem[pm_addr];
  end

  // Control and working registers.
  pct_pkg::state_t state_r, state_nxt;
  logic [NW-1:0] cursor_r, cursor_nxt;
  logic [FW-1:0] free_r, free_nxt;
  logic [DW-1:0] depth_r, depth_nxt;
  logic          missed_r, missed_nxt;
  logic          ovf_r, ovf_nxt;
  logic [ALPHABET-1:0] root_ok_r, root_ok_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          found_r, found_nxt;
  logic [1:0]    req_r, req_nxt;
  logic [AW-1:0] let_r, let_nxt;
  logic          last_r, last_nxt;
  logic [NW-1:0] node_r, node_nxt;
  logic [AW-1:0] k_r, k_nxt;
  logic [DW-1:0] idx_r, idx_nxt;
  logic [COUNT_WIDTH-1:0] sub_r, sub_nxt;

  logic let_ok, root_row;
  logic [NW-1:0] child_val;

  // The shared address multiply-add: node*ALPHABET + letter.
  function automatic logic [SW-1:0] slot(input logic [NW-1:0] n, input logic [AW-1:0] l);
    return SW'(n * ALPHABET) + SW'(l);
  endfunction

  assign let_ok   = ({27'b0, in_letter} < 32'(ALPHABET));
  assign root_row = (cursor_r == '0);
  // Root row entries that were cleared and never written read as zero.
  assign child_val = (root_row && !root_ok_r[let_r]) ? '0 : cm_rdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pct_pkg::ST_IDLE;
      cursor_r    <= '0;
      free_r      <= FW'(1);
      depth_r     <= '0;
      missed_r    <= 1'b0;
      ovf_r       <= 1'b0;
      root_ok_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      free_r      <= free_nxt;
      depth_r     <= depth_nxt;
      missed_r    <= missed_nxt;
      ovf_r       <= ovf_nxt;
      root_ok_r   <= root_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    found_r <= found_nxt;
    req_r   <= req_nxt;
    let_r   <= let_nxt;
    last_r  <= last_nxt;
    node_r  <= node_nxt;
    k_r     <= k_nxt;
    idx_r   <= idx_nxt;
    sub_r   <= sub_nxt;
  end

  assign in_ready     = (state_r == pct_pkg::ST_IDLE) && !out_valid_r;
  assign out_valid    = out_valid_r;
  assign out_found    = found_r;
  assign out_overflow = ovf_r;

  always_comb begin
    state_nxt     = state_r;
    cursor_nxt    = cursor_r;
    free_nxt      = free_r;
    depth_nxt     = depth_r;
    missed_nxt    = missed_r;
    ovf_nxt       = ovf_r;
    root_ok_nxt   = root_ok_r;
    out_valid_nxt = out_valid_r && !out_ready;
    found_nxt     = found_r;
    req_nxt       = req_r;
    let_nxt       = let_r;
    last_nxt      = last_r;
    node_nxt      = node_r;
    k_nxt         = k_r;
    idx_nxt       = idx_r;
    sub_nxt       = sub_r;
    cm_addr  = slot(cursor_r, let_r);
    cm_we    = 1'b0;
    cm_wdata = '0;
    ct_addr  = node_r;
    ct_we    = 1'b0;
    ct_wdata = '0;
    pm_addr  = idx_r[PW-1:0];
    pm_we    = 1'b0;
    pm_wdata = node_r;

    unique case (state_r)
      pct_pkg::ST_IDLE: begin
        if (in_valid && in_ready) begin
          req_nxt  = in_req_type;
          let_nxt  = AW'(in_letter);
          last_nxt = in_last;
          k_nxt    = '0;
          if (in_req_type == pct_pkg::REQ_CLEAR) begin
            node_nxt   = '0;
            free_nxt   = FW'(1);
            cursor_nxt = '0;
            depth_nxt  = '0;
            missed_nxt = 1'b0;
            root_ok_nxt = '0;
            state_nxt  = pct_pkg::ST_IDLE;
          end else if (missed_r) begin
            state_nxt = pct_pkg::ST_DECIDE;
          end else if (in_req_type == pct_pkg::REQ_INSERT && !let_ok) begin
            state_nxt = pct_pkg::ST_DECIDE;
          end else if (in_req_type == pct_pkg::REQ_DELETE &&
                       depth_r >= DW'(MAX_LEN)) begin
            // A full path store wins over a bad letter.
            ovf_nxt    = 1'b1;
            missed_nxt = 1'b1;
            state_nxt  = pct_pkg::ST_DECIDE;
          end else if (!let_ok) begin
            missed_nxt = 1'b1;
            state_nxt  = pct_pkg::ST_DECIDE;
          end else begin
            state_nxt = pct_pkg::ST_RD_CHILD;
          end
        end
      end

      pct_pkg::ST_RD_CHILD: begin
        state_nxt = pct_pkg::ST_WAIT_CHILD;
      end

      // Read data for slot(cursor, letter) is valid here.
      pct_pkg::ST_WAIT_CHILD: begin
        state_nxt = pct_pkg::ST_DECIDE;
        unique case (pct_pkg::req_t'(req_r))
          pct_pkg::REQ_INSERT: begin
            if (child_val != '0) begin
              node_nxt   = child_val;
              cursor_nxt = child_val;
              state_nxt  = pct_pkg::ST_RD_COUNT;
            end else if (free_r >= FW'(NODES)) begin
              ovf_nxt    = 1'b1;
              missed_nxt = 1'b1;
            end else begin
              node_nxt  = free_r[NW-1:0];
              free_nxt  = free_r + FW'(1);
              state_nxt = pct_pkg::ST_ZERO_ROW;
            end
          end
          default: begin
            if (child_val == '0) begin
              missed_nxt = 1'b1;
            end else begin
              cursor_nxt = child_val;
              node_nxt   = child_val;
              if (req_r == pct_pkg::REQ_DELETE) begin
                pm_addr   = depth_r[PW-1:0];
                pm_we     = 1'b1;
                pm_wdata  = child_val;
                depth_nxt = depth_r + DW'(1);
              end
            end
          end
        endcase
      end

      // Zero the row of node_r; for a new insert node, also zero its count.
      pct_pkg::ST_ZERO_ROW: begin
        cm_addr = slot(node_r, k_r);
        cm_we   = 1'b1;
        if (node_r == '0) begin
          root_ok_nxt = '0;
        end
        k_nxt = k_r + AW'(1);
        if (k_r == AW'(ALPHABET - 1)) begin
          if (req_r == pct_pkg::REQ_INSERT) begin
            ct_we     = 1'b1;
            state_nxt = pct_pkg::ST_WR_COUNT;
          end else begin
            state_nxt = pct_pkg::ST_DECIDE;
          end
        end
      end

      // Link the new node and set its count to one.
      pct_pkg::ST_WR_COUNT: begin
        cm_addr  = slot(cursor_r, let_r);
        cm_we    = 1'b1;
        cm_wdata = node_r;
        if (root_row) begin
          root_ok_nxt[let_r] = 1'b1;
        end
        ct_we      = 1'b1;
        ct_wdata   = COUNT_WIDTH'(1);
        cursor_nxt = node_r;
        state_nxt  = pct_pkg::ST_DECIDE;
      end

      pct_pkg::ST_RD_COUNT: begin
        state_nxt = pct_pkg::ST_WAIT_COUNT;
      end

      pct_pkg::ST_WAIT_COUNT: begin
        if (req_r == pct_pkg::REQ_INSERT) begin
          ct_we    = (ct_rdata_r != CMAX);
          ct_wdata = ct_rdata_r + COUNT_WIDTH'(1);
          state_nxt = pct_pkg::ST_DECIDE;
        end else begin
          found_nxt     = !missed_r && (cursor_r != '0) && (ct_rdata_r != '0);
          out_valid_nxt = 1'b1;
          state_nxt     = pct_pkg::ST_OUT;
        end
      end

      // End-of-item decisions.
      pct_pkg::ST_DECIDE: begin
        state_nxt = pct_pkg::ST_OUT;
        if (last_r) begin
          if (req_r == pct_pkg::REQ_QUERY) begin
            node_nxt  = cursor_r;
            state_nxt = pct_pkg::ST_RD_COUNT;
          end else if (req_r == pct_pkg::REQ_DELETE && !missed_r &&
                       depth_r != '0) begin
            node_nxt  = cursor_r;
            state_nxt = pct_pkg::ST_DEL_CNT;
          end
        end
      end

      pct_pkg::ST_DEL_CNT: begin
        state_nxt = pct_pkg::ST_DEL_CNT_W;
      end

      pct_pkg::ST_DEL_CNT_W: begin
        sub_nxt   = ct_rdata_r;
        idx_nxt   = '0;
        state_nxt = pct_pkg::ST_DEL_PATH;
      end

      pct_pkg::ST_DEL_PATH: begin
        state_nxt = pct_pkg::ST_DEL_PWAIT;
      end

      pct_pkg::ST_DEL_PWAIT: begin
        state_nxt = pct_pkg::ST_DEL_NRD;
      end

      pct_pkg::ST_DEL_NRD: begin
        ct_addr   = pm_rdata_r;
        state_nxt = pct_pkg::ST_DEL_NWAIT;
      end

      pct_pkg::ST_DEL_NWAIT: begin
        ct_addr   = pm_rdata_r;
        state_nxt = pct_pkg::ST_DEL_NWR;
      end

      pct_pkg::ST_DEL_NWR: begin
        ct_addr  = pm_rdata_r;
        ct_we    = 1'b1;
        ct_wdata = (ct_rdata_r > sub_r) ? ct_rdata_r - sub_r : '0;
        idx_nxt  = idx_r + DW'(1);
        if (idx_r + DW'(1) >= depth_r) begin
          node_nxt  = cursor_r;
          k_nxt     = '0;
          state_nxt = pct_pkg::ST_ZERO_ROW;
          last_nxt  = 1'b1;
          req_nxt   = pct_pkg::REQ_CLEAR;
        end else begin
          state_nxt = pct_pkg::ST_DEL_PATH;
        end
      end

      // Wait for a query result to drain, then finish the string if last.
      pct_pkg::ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          if (last_r) begin
            cursor_nxt = '0;
            depth_nxt  = '0;
            missed_nxt = 1'b0;
          end
          state_nxt = pct_pkg::ST_IDLE;
        end
      end

      default: state_nxt = pct_pkg::ST_IDLE;
    endcase

    // A clear runs its row sweep through the same zeroing state.
    if (state_r == pct_pkg::ST_IDLE && in_valid && in_ready &&
        in_req_type == pct_pkg::REQ_CLEAR) begin
      state_nxt = pct_pkg::ST_ZERO_ROW;
    end
    // Cut rows of a delete and the clear sweep end the string afterwards.
    if (state_r == pct_pkg::ST_ZERO_ROW && req_r == pct_pkg::REQ_CLEAR &&
        k_r == AW'(ALPHABET - 1)) begin
      state_nxt = pct_pkg::ST_OUT;
    end
  end

endmodule

/* sv/pct_checker.sv */
// Port-level checker for prefix_count_trie, with its bind statement.
// Depends on prefix_count_trie's ports only.
module pct_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_found,
  input logic out_overflow
);

  // The overflow flag is sticky between resets.
  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_overflow |=> out_overflow) else $error("overflow flag fell");

  // No item is taken while a result waits.
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("ready while result pending");

  // An accepted item keeps the block busy for the next cycle.
  a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("ready right after accept");

  // A pending result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found))
    else $error("result changed while stalled");

endmodule

bind prefix_count_trie pct_checker u_pct_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_found(out_found),
  .out_overflow(out_overflow)
);
